@@ hdl/length_prefixed_int_array_decoder_unit_assert.svh @@
// Assertion macros shared by the decoder checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef LENGTH_PREFIXED_INT_ARRAY_DECODER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_INT_ARRAY_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define LPID_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpid assertion failed");

// Next-cycle implication, switched off while reset is high.
`define LPID_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpid assertion failed");

// Next-cycle implication that also holds across reset.
`define LPID_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lpid assertion failed");

`endif

@@ hdl/lpid_pkg.sv @@
// Types and constants of the length-prefixed integer array decoder.
// Depends on nothing; used by the interfaces, the modules and the checker.
package lpid_pkg;

  // Decoder phase: which kind of byte is expected next.
  typedef enum logic [2:0] {
    PH_CNT_LEN  = 3'd0,
    PH_CNT_DATA = 3'd1,
    PH_EL_LEN   = 3'd2,
    PH_EL_DATA  = 3'd3,
    PH_DROP     = 3'd4
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ELEMENT = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_WIDE    = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] element_value;
    status_t            status;
    logic               last_of_array;
  } result_t;

  // Length byte fields.
  localparam logic [7:0] SIGN_MASK = 8'h80;
  localparam logic [7:0] LEN_MASK  = 8'h7F;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // Result queue depth; a request can add two results at once.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

endpackage

@@ hdl/lpid_if.sv @@
// Valid/ready channel interfaces of the decoder: byte requests in, results out.
// Depends on lpid_pkg for the result status type.
interface lpid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       buffer_end;

  modport source (output valid, output byte_in, output buffer_end, input ready);
  modport sink   (input valid, input byte_in, input buffer_end, output ready);
endinterface

interface lpid_res_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  element_value;
  lpid_pkg::status_t   status;
  logic                last_of_array;

  modport source (output valid, output element_value, output status,
                  output last_of_array, input ready);
  modport sink   (input valid, input element_value, input status,
                  input last_of_array, output ready);
endinterface

@@ hdl/lpid_res_fifo.sv @@
// Four-entry result queue that takes zero, one or two results per cycle.
// Depends on lpid_pkg for the result type and queue sizes.
module lpid_res_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_cnt,
  input  lpid_pkg::result_t wr_data0,
  input  lpid_pkg::result_t wr_data1,
  input  logic              pop,
  output logic              rd_valid,
  output lpid_pkg::result_t rd_data,
  output logic              room2
);

  lpid_pkg::result_t                   mem [lpid_pkg::RES_DEPTH];
  logic [lpid_pkg::RES_PTR_W-1:0]      wr_ptr;
  logic [lpid_pkg::RES_PTR_W-1:0]      rd_ptr;
  logic [lpid_pkg::RES_CNT_W-1:0]      count;
  logic                                do_pop;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_pop   = pop && rd_valid;
  // Room for a full pair of results, so a request never has to be split.
  assign room2    = (count <= lpid_pkg::RES_CNT_W'(lpid_pkg::RES_DEPTH - 2));

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= wr_data0;
    end
    if (push_cnt == 2'd2) begin
      mem[lpid_pkg::RES_PTR_W'(wr_ptr + 1'b1)] <= wr_data1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= lpid_pkg::RES_PTR_W'(wr_ptr + push_cnt);
      if (do_pop) begin
        rd_ptr <= lpid_pkg::RES_PTR_W'(rd_ptr + 1'b1);
      end
      count <= lpid_pkg::RES_CNT_W'(count + lpid_pkg::RES_CNT_W'(push_cnt)
               - lpid_pkg::RES_CNT_W'(do_pop));
    end
  end

endmodule

@@ hdl/length_prefixed_int_array_decoder_unit.sv @@
// Length-prefixed sign-magnitude integer array decoder, top level.
// Depends on lpid_pkg, lpid_if.sv and lpid_res_fifo.
//
// Usage: the bytes channel carries one byte of the encoded buffer per request,
// with buffer_end set on the last byte. An array is a count, then that many
// elements; each is a length byte (bit 7 sign, low bits 0..VALUE_BYTES
// magnitude bytes) and a big-endian magnitude. The results channel gives one
// result per decoded element and one status result per empty array, too-wide
// value or early buffer end; a single byte can give two results.
// A result enters the result queue when the byte that completes it is
// accepted, behind any older results. Throughput: one byte per cycle while
// the queue has two free entries; the decode is one combinational pass from
// the state registers into the four-entry result queue.
// A stalled receiver fills the queue and then holds bytes.ready low; no
// result is lost. Reset empties the queue and returns the decoder to
// expecting a count length byte.
module length_prefixed_int_array_decoder_unit #(
  parameter int unsigned VALUE_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst,
  lpid_byte_if.sink      bytes,
  lpid_res_if.source     results
);

  localparam int unsigned ACC_W = 8 * VALUE_BYTES;
  localparam int unsigned BL_W  = $clog2(VALUE_BYTES + 1);

  // Decoder state.
  lpid_pkg::phase_t  phase, phase_next;
  logic [BL_W-1:0]   bytes_left, bytes_left_next;
  logic [ACC_W-1:0]  accumulator, accumulator_next;
  logic              negative_flag, negative_flag_next;
  logic [30:0]       elements_left, elements_left_next;

  // Decode temporaries.
  logic [ACC_W-1:0]  acc_shift;
  logic [BL_W-1:0]   bl_dec;
  logic [6:0]        len;
  logic              fin;
  logic              fin_count;
  logic [ACC_W-1:0]  fin_acc;
  logic              fin_neg;
  logic [63:0]       fin_wide;
  logic [31:0]       mag;
  logic [30:0]       el_dec;
  logic              el_last;
  logic [1:0]        n_res;
  lpid_pkg::result_t res0, res1, res_main;
  logic              main_valid;

  logic              accept;
  logic              room2;
  lpid_pkg::result_t rd_data;

  assign accept      = bytes.valid && bytes.ready;
  assign bytes.ready = room2;

  // Single-pass decode of one byte against the current state.
  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    accumulator_next   = accumulator;
    negative_flag_next = negative_flag;
    elements_left_next = elements_left;
    acc_shift          = ACC_W'({accumulator, bytes.byte_in});
    bl_dec             = (bytes_left != '0) ? BL_W'(bytes_left - 1'b1) : bytes_left;
    len                = 7'(bytes.byte_in & lpid_pkg::LEN_MASK);
    fin                = 1'b0;
    fin_count          = 1'b0;
    fin_acc            = accumulator;
    fin_neg            = negative_flag;
    fin_wide           = 64'(fin_acc);
    mag                = '0;
    el_dec             = elements_left;
    el_last            = 1'b0;
    main_valid         = 1'b0;
    res_main           = '{element_value: '0, status: lpid_pkg::ST_ELEMENT,
                           last_of_array: 1'b1};
    res0               = res_main;
    res1               = res_main;
    n_res              = 2'd0;

    case (phase)
      lpid_pkg::PH_CNT_DATA, lpid_pkg::PH_EL_DATA: begin
        accumulator_next = acc_shift;
        bytes_left_next  = bl_dec;
        if (bl_dec == '0) begin
          fin       = 1'b1;
          fin_count = (phase == lpid_pkg::PH_CNT_DATA);
          fin_acc   = acc_shift;
        end
      end
      lpid_pkg::PH_DROP: begin
      end
      default: begin
        // Length byte of a count or an element.
        negative_flag_next = (bytes.byte_in & lpid_pkg::SIGN_MASK) != 8'h00;
        accumulator_next   = '0;
        fin_neg            = negative_flag_next;
        fin_acc            = '0;
        if (len > 7'(VALUE_BYTES)) begin
          phase_next         = lpid_pkg::PH_DROP;
          elements_left_next = '0;
          main_valid         = 1'b1;
          res_main.status    = lpid_pkg::ST_WIDE;
        end else if (len == 7'd0) begin
          fin       = 1'b1;
          fin_count = (phase != lpid_pkg::PH_EL_LEN);
        end else begin
          bytes_left_next = BL_W'(len);
          phase_next      = (phase == lpid_pkg::PH_EL_LEN) ? lpid_pkg::PH_EL_DATA
                                                           : lpid_pkg::PH_CNT_DATA;
        end
      end
    endcase

    // Completed value: range check, then count or element handling.
    fin_wide = 64'(fin_acc);
    mag      = 32'(fin_acc);
    if (fin) begin
      if (|fin_wide[63:31]) begin
        phase_next         = lpid_pkg::PH_DROP;
        elements_left_next = '0;
        main_valid         = 1'b1;
        res_main.status    = lpid_pkg::ST_WIDE;
      end else if (fin_count) begin
        if (fin_neg || (fin_acc == '0)) begin
          phase_next         = lpid_pkg::PH_CNT_LEN;
          elements_left_next = '0;
          main_valid         = 1'b1;
          res_main.status    = lpid_pkg::ST_EMPTY;
        end else begin
          elements_left_next = 31'(fin_acc);
          phase_next         = lpid_pkg::PH_EL_LEN;
        end
      end else begin
        el_dec                 = (elements_left != '0) ? 31'(elements_left - 1'b1)
                                                       : elements_left;
        el_last                = (el_dec == '0);
        elements_left_next     = el_dec;
        phase_next             = el_last ? lpid_pkg::PH_CNT_LEN : lpid_pkg::PH_EL_LEN;
        main_valid             = 1'b1;
        res_main.status        = lpid_pkg::ST_ELEMENT;
        res_main.last_of_array = el_last;
        res_main.element_value = fin_neg ? $signed(32'd0 - mag) : $signed(mag);
      end
    end

    if (main_valid) begin
      res0  = res_main;
      n_res = 2'd1;
    end

    // Buffer end: flag an unfinished array or value, then start over.
    if (bytes.buffer_end) begin
      if ((phase_next != lpid_pkg::PH_CNT_LEN) && (phase_next != lpid_pkg::PH_DROP)) begin
        if (main_valid) begin
          res1.status = lpid_pkg::ST_TRUNC;
          n_res       = 2'd2;
        end else begin
          res0.status = lpid_pkg::ST_TRUNC;
          n_res       = 2'd1;
        end
      end
      phase_next         = lpid_pkg::PH_CNT_LEN;
      bytes_left_next    = '0;
      accumulator_next   = '0;
      negative_flag_next = 1'b0;
      elements_left_next = '0;
    end
  end

  // State registers, updated on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lpid_pkg::PH_CNT_LEN;
      bytes_left    <= '0;
      accumulator   <= '0;
      negative_flag <= 1'b0;
      elements_left <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      accumulator   <= accumulator_next;
      negative_flag <= negative_flag_next;
      elements_left <= elements_left_next;
    end
  end

  // Result queue between the decoder and the receiver.
  lpid_res_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (accept ? n_res : 2'd0),
    .wr_data0 (res0),
    .wr_data1 (res1),
    .pop      (results.ready),
    .rd_valid (results.valid),
    .rd_data  (rd_data),
    .room2    (room2)
  );

  assign results.element_value = rd_data.element_value;
  assign results.status        = rd_data.status;
  assign results.last_of_array = rd_data.last_of_array;

endmodule

@@ hdl/lpid_checker.sv @@
// Port-level checker for the decoder top level, attached by bind.
// Depends on lpid_pkg and the assertion macros header.
`include "length_prefixed_int_array_decoder_unit_assert.svh"

module lpid_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [31:0]       out_value,
  input lpid_pkg::status_t out_status,
  input logic              out_last
);

  // Status results carry a zero value and always close the array.
  `LPID_ASSERT_IMPLY(a_status_zero, clk, rst, out_valid && (out_status != lpid_pkg::ST_ELEMENT), out_value == 32'd0)
  `LPID_ASSERT_IMPLY(a_status_last, clk, rst, out_valid && (out_status != lpid_pkg::ST_ELEMENT), out_last)

  // A stalled result holds.
  `LPID_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status))

  // Reset empties the result queue.
  `LPID_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind length_prefixed_int_array_decoder_unit lpid_checker u_lpid_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.element_value),
  .out_status (results.status),
  .out_last   (results.last_of_array)
);

@@ tb/length_prefixed_int_array_decoder_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the length-prefixed integer array decoder.
// Depends on lpid_pkg, lpid_if.sv and length_prefixed_int_array_decoder_unit.
module length_prefixed_int_array_decoder_unit_test;
  import lpid_pkg::*;

  localparam int unsigned VALUE_BYTES  = 4;
  localparam int unsigned RANDOM_BYTES = 1150;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam logic [31:0] SIGNED_MAX   = 32'h7FFF_FFFF;

  // Directed buffers, written as {buffer_end, byte}.
  localparam logic [8:0] DIRECTED [26] = '{
    // Zero count, then minus zero.
    9'h000, 9'h080,
    // Negative count of one magnitude byte.
    9'h081, 9'h005,
    // Count of two: the most positive element negated, then the most positive element.
    9'h001, 9'h002, 9'h084, 9'h07F, 9'h0FF, 9'h0FF, 9'h0FF,
    9'h004, 9'h07F, 9'h0FF, 9'h0FF, 9'h0FF,
    // Length field far too wide; the rest of the buffer is dropped.
    9'h0FF, 9'h100,
    // Count magnitude just past the signed maximum.
    9'h004, 9'h080, 9'h000, 9'h000, 9'h100,
    // Zero-length element on the last byte while one more is owed.
    9'h001, 9'h002, 9'h180
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } byte_req_t;

  logic clk;
  logic rst;

  lpid_byte_if byte_ch ();
  lpid_res_if  result_ch ();

  length_prefixed_int_array_decoder_unit #(
    .VALUE_BYTES(VALUE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .bytes(byte_ch),
    .results(result_ch)
  );

  // Decoder state mirrored by the predictor.
  phase_t      dec_phase = PH_CNT_LEN;
  int unsigned dec_left  = 0;
  logic [63:0] dec_acc   = '0;
  bit          dec_neg   = 1'b0;
  logic [31:0] dec_elems = '0;

  result_t     due_results [$];
  byte_req_t   byte_requests [$];
  logic [7:0]  draft_bytes [$];
  byte_req_t   next_req;

  int unsigned send_gap    = 0;
  int unsigned recv_gap    = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count  = 0;
  bit          calm        = 1'b0;

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor.
  function automatic void add_due(logic [31:0] value, status_t st, logic last);
    result_t r;
    r.element_value = value;
    r.status        = st;
    r.last_of_array = last;
    due_results.insert(due_results.size(), r);
  endfunction

  // A count or element magnitude is complete.
  function automatic void close_value(bit is_count);
    logic [31:0] mag;
    if (dec_acc > {32'h0, SIGNED_MAX}) begin
      dec_phase = PH_DROP;
      dec_elems = '0;
      add_due('0, ST_WIDE, 1'b1);
    end else if (is_count) begin
      if (dec_neg || dec_acc == 64'h0) begin
        dec_phase = PH_CNT_LEN;
        dec_elems = '0;
        add_due('0, ST_EMPTY, 1'b1);
      end else begin
        dec_elems = dec_acc[31:0];
        dec_phase = PH_EL_LEN;
      end
    end else begin
      mag = dec_acc[31:0];
      if (dec_elems != 0) dec_elems = dec_elems - 1;
      add_due(dec_neg ? -mag : mag, ST_ELEMENT, dec_elems == 0);
      dec_phase = (dec_elems == 0) ? PH_CNT_LEN : PH_EL_LEN;
    end
  endfunction

  function automatic void open_value(logic [7:0] b, bit is_count);
    int unsigned len;
    len     = b & LEN_MASK;
    dec_neg = (b & SIGN_MASK) != 0;
    dec_acc = '0;
    if (len > VALUE_BYTES) begin
      dec_phase = PH_DROP;
      dec_elems = '0;
      add_due('0, ST_WIDE, 1'b1);
    end else if (len == 0) begin
      close_value(is_count);
    end else begin
      dec_left  = len;
      dec_phase = is_count ? PH_CNT_DATA : PH_EL_DATA;
    end
  endfunction

  function automatic void gather_byte(logic [7:0] b, bit is_count);
    dec_acc = (dec_acc << 8) | {56'h0, b & BYTE_MASK};
    if (dec_left > 0) dec_left = dec_left - 1;
    if (dec_left == 0) close_value(is_count);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    case (dec_phase)
      PH_CNT_DATA: gather_byte(b, 1'b1);
      PH_EL_LEN:   open_value(b, 1'b0);
      PH_EL_DATA:  gather_byte(b, 1'b0);
      PH_DROP:     ;
      default:     open_value(b, 1'b1);
    endcase
    if (last) begin
      if (dec_phase != PH_CNT_LEN && dec_phase != PH_DROP) add_due('0, ST_TRUNC, 1'b1);
      dec_phase = PH_CNT_LEN;
      dec_left  = 0;
      dec_acc   = '0;
      dec_neg   = 1'b0;
      dec_elems = '0;
    end
  endfunction

  // Stimulus helpers.
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_mag(int unsigned len);
    logic [31:0] m;
    m = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
    if (len == 0) m = '0;
    else if (len < 4) m = m & ((32'h1 << (8 * len)) - 32'h1);
    else m[31] = 1'b0;
    return m;
  endfunction

  function automatic int unsigned span_of(logic [31:0] v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 8;
    end
    return n;
  endfunction

  // Length byte, then the magnitude big-endian.
  function automatic void add_value(bit neg, logic [31:0] mag, int unsigned len);
    draft_bytes.insert(draft_bytes.size(), {neg, 7'(len)});
    for (int i = int'(len) - 1; i >= 0; i--)
      draft_bytes.insert(draft_bytes.size(), mag[8 * i +: 8]);
  endfunction

  // Builds one buffer: mostly well-formed arrays, some of them broken on purpose.
  function automatic void make_buffer();
    int unsigned arrays;
    int unsigned count;
    int unsigned len;
    int unsigned pos;
    int unsigned r;
    logic [31:0] mag;
    draft_bytes.delete();
    arrays = $urandom_range(1, 3);
    for (int a = 0; a < int'(arrays); a++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // Empty array: zero of either sign, or a negative count.
        len = $urandom_range(0, 4);
        mag = rand_mag(len);
        add_value((mag == 0) ? 1'($urandom_range(0, 1)) : 1'b1, mag, len);
        count = 0;
      end else begin
        count = (r < 90) ? $urandom_range(1, 6) : $urandom_range(7, 20);
        len = span_of(count);
        len = len + $urandom_range(0, 4 - len);
        add_value(1'b0, count, len);
      end
      for (int k = 0; k < int'(count); k++) begin
        len = $urandom_range(0, 4);
        add_value(1'($urandom_range(0, 1)), rand_mag(len), len);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // Cut the buffer short.
      pos = $urandom_range(1, draft_bytes.size());
      while (draft_bytes.size() > pos) void'(draft_bytes.pop_back());
    end else if (r < 15) begin
      // Length field wider than the value.
      pos = $urandom_range(0, draft_bytes.size());
      draft_bytes.insert(pos, {1'($urandom_range(0, 1)), 7'($urandom_range(5, 127))});
    end else if (r < 20) begin
      // Four magnitude bytes above the signed maximum.
      pos = $urandom_range(0, draft_bytes.size());
      draft_bytes.insert(pos, {1'($urandom_range(0, 1)), 7'd4});
      draft_bytes.insert(pos + 1, 8'h80 | 8'($urandom));
      for (int i = 2; i < 5; i++) draft_bytes.insert(pos + i, 8'($urandom));
    end else if (r < 25) begin
      // One byte replaced by noise.
      pos = $urandom_range(0, draft_bytes.size() - 1);
      draft_bytes[pos] = 8'($urandom);
    end else if (r < 28) begin
      // A huge count that the buffer never fulfills.
      draft_bytes.delete();
      add_value(1'b0, ($urandom | 32'h0100_0000) & SIGNED_MAX, 4);
      for (int k = $urandom_range(0, 3); k > 0; k--) begin
        len = $urandom_range(0, 4);
        add_value(1'($urandom_range(0, 1)), rand_mag(len), len);
      end
    end
  endfunction

  function automatic void queue_request(logic [7:0] data, logic last, bit drain);
    byte_req_t req;
    req.data  = data;
    req.last  = last;
    req.drain = drain;
    byte_requests.insert(byte_requests.size(), req);
  endfunction

  // Occasional stretches with no idling on either side.
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  // Byte driver: predicts each accepted request, then presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) decode_byte(byte_ch.byte_in, byte_ch.buffer_end);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          byte_ch.valid <= 1'b0;
        end else if (byte_requests.size() > 0 &&
                     !(byte_requests[0].drain && due_results.size() > 0)) begin
          next_req = byte_requests.pop_front();
          byte_ch.valid      <= 1'b1;
          byte_ch.byte_in    <= next_req.data;
          byte_ch.buffer_end <= next_req.last;
          send_gap <= next_gap();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d last %0b", $time,
                   result_ch.element_value, result_ch.status, result_ch.last_of_array);
          fail_count++;
        end else begin
          if (result_ch.element_value !== due_results[0].element_value) begin
            $display("%0t: element_value expected %0d, got %0d", $time,
                     due_results[0].element_value, result_ch.element_value);
            fail_count++;
          end
          if (result_ch.status !== due_results[0].status) begin
            $display("%0t: status expected %0d, got %0d", $time,
                     due_results[0].status, result_ch.status);
            fail_count++;
          end
          if (result_ch.last_of_array !== due_results[0].last_of_array) begin
            $display("%0t: last_of_array expected %0b, got %0b", $time,
                     due_results[0].last_of_array, result_ch.last_of_array);
            fail_count++;
          end
          void'(due_results.pop_front());
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        recv_gap <= next_gap();
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned random_bytes;
    int unsigned buffers;
    byte_ch.valid      = 1'b0;
    byte_ch.byte_in    = '0;
    byte_ch.buffer_end = 1'b0;
    result_ch.ready    = 1'b0;
    rst = 1'b1;

    foreach (DIRECTED[i]) queue_request(DIRECTED[i][7:0], DIRECTED[i][8], 1'b0);

    // Random buffers; every so often the sender holds until all results are in.
    random_bytes = 0;
    buffers = 0;
    while (random_bytes < RANDOM_BYTES) begin
      make_buffer();
      foreach (draft_bytes[i])
        queue_request(draft_bytes[i], i == draft_bytes.size() - 1,
                      i == 0 && buffers % 40 == 0);
      random_bytes += draft_bytes.size();
      buffers++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (byte_requests.size() != 0 || byte_ch.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
